FILE: design/uvs_pkg.sv
// Shared types and constants of the UV sphere mesh generator.
// Depends on nothing; the top level, front, queue and back end import it.
`default_nettype none

package uvs_pkg;

    // Widths of the carried ring/band indices and latched divisors.
    localparam int IDX_W = 8;
    localparam int DIV_W = 9;
    localparam int CORNER_W = 12;
    localparam int COORD_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_DIVS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LNG_DIVS = 2'd1;

    localparam logic [CFG_DATA_W-1:0] DIVS_RESET = 7'd8;

    // Quarter-wave sine polynomial coefficients in unsigned Q30.
    localparam logic [30:0] K1 = 31'd1686629713;
    localparam logic [30:0] K3 = 31'd693598668;
    localparam logic [30:0] K5 = 31'd85569306;
    localparam logic [30:0] K7 = 31'd5026995;
    localparam logic [30:0] K9 = 31'd172272;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;

    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BOTTOM,
        PH_RING,
        PH_TRI
    } gen_phase_t;

    typedef enum logic [1:0] {
        OP_TOP,
        OP_BOTTOM,
        OP_RING,
        OP_TRI
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQ,
        BK_HORN,
        BK_TFIN,
        BK_PX,
        BK_PZ,
        BK_OUT
    } back_state_t;

    // One classified command from the front to the back.
    typedef struct packed {
        op_t                 op;
        logic [IDX_W-1:0]    ring;
        logic [IDX_W-1:0]    band;
        logic [DIV_W-1:0]    nb_lat;
        logic [DIV_W-1:0]    nb_lng;
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic                final_item;
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/uvs_ifc.sv
// Channel interfaces of the UV sphere mesh generator: request, result, configuration.
// Depends on nothing; field widths are written out as literals.
`default_nettype none

interface uvs_req_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface uvs_res_if;
    logic                valid;
    logic                ready;
    logic                item_kind;
    logic signed [15:0]  pos_x;
    logic signed [15:0]  pos_y;
    logic signed [15:0]  pos_z;
    logic [11:0]         corner_a;
    logic [11:0]         corner_b;
    logic [11:0]         corner_c;
    logic                final_item;
    modport source (output valid, output item_kind, output pos_x, output pos_y,
                    output pos_z, output corner_a, output corner_b, output corner_c,
                    output final_item, input ready);
    modport sink (input valid, input item_kind, input pos_x, input pos_y,
                  input pos_z, input corner_a, input corner_b, input corner_c,
                  input final_item, output ready);
endinterface

interface uvs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/uv_sphere_mesh_generator.sv
// Top level of the UV sphere mesh generator: front end, command queue, back end.
// Depends on uvs_pkg, uvs_ifc, uvs_front, uvs_queue and uvs_back.
//
//   channel  direction  handshake        payload
//   cfg      in         valid / ready    index (2 bits), data (7 bits)
//   req      in         valid / ready    restart
//   res      out        valid / ready    item_kind, pos_x/y/z, corner_a/b/c, final_item
//
// A pole vertex or a triangle passes from its request transfer through a queue slot into
// the result register. A ring vertex takes two 16-bit angle divisions and four sines of
// six steps each on the one shared 31x31 multiplier, then two scaled products.
// Reset clears all control state; the divisor registers come up at eight.
// Requests are taken while the two-entry queue has room, so the front keeps accepting
// while the back end works or a result waits for its transfer.
`default_nettype none

module uv_sphere_mesh_generator #(
    parameter int MAX_DIVS = 64,
    parameter int FRAC_BITS = 15
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    uvs_cfg_if.sink    cfg,
    uvs_req_if.sink    req,
    uvs_res_if.source  res
);
    import uvs_pkg::*;

    // Commands travel from the front to the back through this queue.
    logic q_push, q_pop, q_full, q_empty;
    cmd_t q_push_cmd, q_head;

    uvs_front #(.MAX_DIVS(MAX_DIVS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req      (req),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    uvs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    // The back end owns the result register and drives the result channel.
    uvs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (q_head),
        .pop     (q_pop),
        .res     (res)
    );

endmodule

`default_nettype wire

FILE: design/uvs_front.sv
// Front end: configuration registers, generation sequence and triangle corner indices.
// Depends on uvs_pkg and uvs_ifc; feeds commands into uvs_queue.
`default_nettype none

module uvs_front #(
    parameter int MAX_DIVS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    uvs_cfg_if.sink          cfg,
    uvs_req_if.sink          req,
    input  wire logic        q_full,
    output logic             push,
    output uvs_pkg::cmd_t    push_cmd
);
    import uvs_pkg::*;

    logic [CFG_DATA_W-1:0] lat_cfg_reg, lng_cfg_reg;
    gen_phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]      ring_reg, ring_next, band_reg, band_next;
    logic                  half_reg, half_next;
    logic [DIV_W-1:0]      nb_lat_reg, nb_lat_next, nb_lng_reg, nb_lng_next;

    logic                  take;
    logic [DIV_W-1:0]      yn;
    logic [IDX_W:0]        ring_inc, band_inc;
    logic [IDX_W:0]        right_ring;
    logic [2*DIV_W-1:0]    left_full, right_full;
    logic [CORNER_W-1:0]   left, right, iy;
    logic                  is_last_ring;

    function automatic logic [DIV_W-1:0] clampdiv(logic [CFG_DATA_W-1:0] v,
                                                  logic [DIV_W-1:0] lo);
        logic [DIV_W-1:0] w;
        w = DIV_W'(v);
        if (w < lo) return lo;
        if (w > DIV_W'(MAX_DIVS)) return DIV_W'(MAX_DIVS);
        return w;
    endfunction

    assign cfg.ready = 1'b1;
    assign req.ready = !q_full;
    assign take = req.valid && !q_full;

    assign yn = nb_lat_reg - 1'b1;
    assign ring_inc = {1'b0, ring_reg} + 1'b1;
    assign band_inc = {1'b0, band_reg} + 1'b1;
    assign right_ring = (DIV_W'(ring_inc) >= nb_lng_reg) ? '0 : ring_inc;
    assign left_full = (2*DIV_W)'(ring_reg) * (2*DIV_W)'(yn);
    assign right_full = (2*DIV_W)'(right_ring) * (2*DIV_W)'(yn);
    assign left = CORNER_W'(left_full);
    assign right = CORNER_W'(right_full);
    assign iy = CORNER_W'(band_reg);
    assign is_last_ring = (DIV_W'(ring_reg) == nb_lng_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_cfg_reg <= DIVS_RESET;
            lng_cfg_reg <= DIVS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_LAT_DIVS) lat_cfg_reg <= cfg.data;
            else if (cfg.index == CFG_LNG_DIVS) lng_cfg_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            ring_reg   <= '0;
            band_reg   <= '0;
            half_reg   <= 1'b0;
            nb_lat_reg <= DIV_W'(8);
            nb_lng_reg <= DIV_W'(8);
        end
        else
        begin
            phase_reg  <= phase_next;
            ring_reg   <= ring_next;
            band_reg   <= band_next;
            half_reg   <= half_next;
            nb_lat_reg <= nb_lat_next;
            nb_lng_reg <= nb_lng_next;
        end
    end

    // Next state of the generation sequence.
    always_comb
    begin
        phase_next  = phase_reg;
        ring_next   = ring_reg;
        band_next   = band_reg;
        half_next   = half_reg;
        nb_lat_next = nb_lat_reg;
        nb_lng_next = nb_lng_reg;
        if (take)
        begin
            if (req.restart)
            begin
                nb_lat_next = clampdiv(lat_cfg_reg, DIV_W'(2));
                nb_lng_next = clampdiv(lng_cfg_reg, DIV_W'(3));
                ring_next   = '0;
                band_next   = '0;
                half_next   = 1'b0;
                phase_next  = PH_BOTTOM;
            end
            else
            begin
                case (phase_reg)
                    PH_BOTTOM: phase_next = PH_RING;
                    PH_RING:
                    begin
                        band_next = IDX_W'(band_inc);
                        if (DIV_W'(band_inc) >= nb_lat_reg - 1'b1)
                        begin
                            band_next = '0;
                            ring_next = IDX_W'(ring_inc);
                            if (DIV_W'(ring_inc) >= nb_lng_reg)
                            begin
                                ring_next  = '0;
                                phase_next = PH_TRI;
                            end
                        end
                    end
                    PH_TRI:
                    begin
                        if (band_reg != '0 && DIV_W'(band_reg) != yn && !half_reg)
                        begin
                            half_next = 1'b1;
                        end
                        else
                        begin
                            half_next = 1'b0;
                            band_next = IDX_W'(band_inc);
                            if (DIV_W'(band_inc) >= nb_lat_reg)
                            begin
                                band_next = '0;
                                ring_next = IDX_W'(ring_inc);
                            end
                            if (DIV_W'(band_reg) == yn && is_last_ring)
                            begin
                                phase_next = PH_IDLE;
                                ring_next  = '0;
                                band_next  = '0;
                            end
                        end
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    // Command handed to the back end.
    always_comb
    begin
        push = 1'b0;
        push_cmd = '0;
        push_cmd.op = OP_TOP;
        push_cmd.ring = ring_reg;
        push_cmd.band = band_reg;
        push_cmd.nb_lat = nb_lat_reg;
        push_cmd.nb_lng = nb_lng_reg;
        if (take)
        begin
            if (req.restart)
            begin
                push = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_BOTTOM:
                    begin
                        push = 1'b1;
                        push_cmd.op = OP_BOTTOM;
                    end
                    PH_RING:
                    begin
                        push = 1'b1;
                        push_cmd.op = OP_RING;
                    end
                    PH_TRI:
                    begin
                        push = 1'b1;
                        push_cmd.op = OP_TRI;
                        if (band_reg == '0)
                        begin
                            push_cmd.corner_a = '0;
                            push_cmd.corner_b = CORNER_W'(2) + left;
                            push_cmd.corner_c = CORNER_W'(2) + right;
                        end
                        else if (DIV_W'(band_reg) == yn)
                        begin
                            push_cmd.corner_a = CORNER_W'(1);
                            push_cmd.corner_b = CORNER_W'(1) + right + iy;
                            push_cmd.corner_c = CORNER_W'(1) + left + iy;
                            push_cmd.final_item = is_last_ring;
                        end
                        else if (!half_reg)
                        begin
                            push_cmd.corner_a = CORNER_W'(1) + right + iy;
                            push_cmd.corner_b = CORNER_W'(1) + left + iy;
                            push_cmd.corner_c = CORNER_W'(2) + left + iy;
                        end
                        else
                        begin
                            push_cmd.corner_a = CORNER_W'(2) + left + iy;
                            push_cmd.corner_b = CORNER_W'(2) + right + iy;
                            push_cmd.corner_c = CORNER_W'(1) + right + iy;
                        end
                    end
                    default: push = 1'b0;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/uvs_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on uvs_pkg for the command type.
`default_nettype none

module uvs_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire uvs_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output uvs_pkg::cmd_t      head
);
    import uvs_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

FILE: design/uvs_back.sv
// Back end: angle divider, shared-multiplier sine sequencer and the result register.
// Depends on uvs_pkg and uvs_ifc; takes commands from uvs_queue.
`default_nettype none

module uvs_back #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire uvs_pkg::cmd_t head,
    output logic               pop,
    uvs_res_if.source          res
);
    import uvs_pkg::*;

    localparam int HP_S = 61 - FRAC_BITS;
    localparam int HO_S = 31 - FRAC_BITS;
    localparam int NUM_W = 16 + DIV_W;
    localparam logic [63:0] POLE = 64'd1 << (FRAC_BITS - 1);

    back_state_t       state_reg, state_next;
    cmd_t              job_reg;
    logic              div_lng_reg;
    logic [3:0]        div_cnt_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [DIV_W:0]    rem_reg;
    logic [15:0]       quo_reg;
    logic [15:0]       lng_ph_reg, lat_ph_reg;
    logic [1:0]        sin_sel_reg, horn_cnt_reg;
    logic [30:0]       t_reg, u_reg, p_reg;
    logic [30:0]       mag_reg [4];
    logic [3:0]        neg_reg;
    logic [15:0]       x_reg, z_reg;

    logic              out_free, direct_load, ring_load;
    logic [DIV_W:0]    rem_sh;
    logic              rem_ge;
    logic [15:0]       ph;
    logic [13:0]       ph_r;
    logic [14:0]       arg;
    logic [30:0]       t_new;
    logic [30:0]       mul_a, mul_b;
    logic [61:0]       prod;
    logic [30:0]       prod_q30;
    logic [30:0]       horn_k;
    logic [62:0]       hp_sum;
    logic [15:0]       hp_mag;
    logic              hp_neg;
    logic [31:0]       y_sum;
    logic [15:0]       y_mag, y_val;

    assign out_free    = !res.valid || res.ready;
    assign direct_load = (state_reg == BK_IDLE) && !q_empty && head.op != OP_RING && out_free;
    assign ring_load   = (state_reg == BK_IDLE) && !q_empty && head.op == OP_RING;
    assign pop         = direct_load || ring_load;

    // Restoring division, one quotient bit per cycle.
    assign rem_sh = {rem_reg[DIV_W-1:0], num_reg[div_cnt_reg]};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    // Sine argument folding for the current of the four sines.
    assign ph    = (sin_sel_reg[1] ? lat_ph_reg : lng_ph_reg)
                   + (sin_sel_reg[0] ? QUARTER_TURN : 16'd0);
    assign ph_r  = ph[13:0];
    assign arg   = ph[14] ? (15'd16384 - {1'b0, ph_r}) : {1'b0, ph_r};
    assign t_new = {arg, 16'd0};

    always_comb
    begin
        case (state_reg)
            BK_SQ:   begin mul_a = t_new;      mul_b = t_new;      end
            BK_HORN: begin mul_a = p_reg;      mul_b = u_reg;      end
            BK_TFIN: begin mul_a = p_reg;      mul_b = t_reg;      end
            BK_PX:   begin mul_a = mag_reg[0]; mul_b = mag_reg[2]; end
            BK_PZ:   begin mul_a = mag_reg[1]; mul_b = mag_reg[2]; end
            default: begin mul_a = '0;         mul_b = '0;         end
        endcase
    end

    assign prod     = {31'd0, mul_a} * {31'd0, mul_b};
    assign prod_q30 = prod[60:30];

    always_comb
    begin
        case (horn_cnt_reg)
            2'd0:    horn_k = K7;
            2'd1:    horn_k = K5;
            2'd2:    horn_k = K3;
            default: horn_k = K1;
        endcase
    end

    assign hp_sum = {1'b0, prod} + (63'd1 << (HP_S - 1));
    assign hp_mag = 16'(hp_sum >> HP_S);
    assign hp_neg = (state_reg == BK_PX) ? (neg_reg[0] ^ neg_reg[2])
                                         : (neg_reg[1] ^ neg_reg[2]);

    assign y_sum = {1'b0, mag_reg[3]} + (32'd1 << (HO_S - 1));
    assign y_mag = 16'(y_sum >> HO_S);
    assign y_val = neg_reg[3] ? (16'd0 - y_mag) : y_mag;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (ring_load) state_next = BK_DIV;
            BK_DIV:  if (div_cnt_reg == 4'd0 && !div_lng_reg) state_next = BK_SQ;
            BK_SQ:   state_next = BK_HORN;
            BK_HORN: if (horn_cnt_reg == 2'd3) state_next = BK_TFIN;
            BK_TFIN: state_next = (sin_sel_reg == 2'd3) ? BK_PX : BK_SQ;
            BK_PX:   state_next = BK_PZ;
            BK_PZ:   state_next = BK_OUT;
            BK_OUT:  if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            res.valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (direct_load || (state_reg == BK_OUT && out_free)) res.valid <= 1'b1;
            else if (res.ready) res.valid <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (ring_load)
                begin
                    job_reg     <= head;
                    div_lng_reg <= 1'b1;
                    div_cnt_reg <= 4'd15;
                    num_reg     <= NUM_W'({head.ring, 16'd0}) + NUM_W'(head.nb_lng >> 1);
                    den_reg     <= head.nb_lng;
                    rem_reg     <= {1'b0, head.ring, 1'b0} >> 1;
                end
            end
            BK_DIV:
            begin
                quo_reg[div_cnt_reg] <= rem_ge;
                if (div_cnt_reg == 4'd0 && div_lng_reg)
                begin
                    // Longitude phase done; set up the latitude division.
                    lng_ph_reg  <= {quo_reg[15:1], rem_ge};
                    div_lng_reg <= 1'b0;
                    div_cnt_reg <= 4'd15;
                    num_reg     <= ((NUM_W'(job_reg.band) + 1'b1) << 15)
                                   + NUM_W'(job_reg.nb_lat >> 1);
                    den_reg     <= job_reg.nb_lat;
                    rem_reg     <= (DIV_W+1)'(((NUM_W'(job_reg.band) + 1'b1) << 15)
                                   + NUM_W'(job_reg.nb_lat >> 1) >> 16);
                end
                else
                begin
                    rem_reg <= rem_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == 4'd0)
                    begin
                        lat_ph_reg  <= {quo_reg[15:1], rem_ge};
                        sin_sel_reg <= 2'd0;
                    end
                end
            end
            BK_SQ:
            begin
                t_reg <= t_new;
                u_reg <= prod_q30;
                p_reg <= K9;
                horn_cnt_reg <= 2'd0;
                neg_reg[sin_sel_reg] <= ph[15];
            end
            BK_HORN:
            begin
                p_reg <= horn_k - prod_q30;
                horn_cnt_reg <= horn_cnt_reg + 1'b1;
            end
            BK_TFIN:
            begin
                mag_reg[sin_sel_reg] <= (prod_q30 > ONE_Q30) ? ONE_Q30 : prod_q30;
                sin_sel_reg <= sin_sel_reg + 1'b1;
            end
            BK_PX: x_reg <= hp_neg ? (16'd0 - hp_mag) : hp_mag;
            BK_PZ: z_reg <= hp_neg ? (16'd0 - hp_mag) : hp_mag;
            default: ;
        endcase

        if (direct_load)
        begin
            res.item_kind  <= (head.op == OP_TRI);
            res.pos_x      <= '0;
            res.pos_z      <= '0;
            res.pos_y      <= (head.op == OP_TOP) ? 16'(POLE)
                            : (head.op == OP_BOTTOM) ? 16'(64'd0 - POLE) : 16'd0;
            res.corner_a   <= head.corner_a;
            res.corner_b   <= head.corner_b;
            res.corner_c   <= head.corner_c;
            res.final_item <= head.final_item;
        end
        else if (state_reg == BK_OUT && out_free)
        begin
            res.item_kind  <= 1'b0;
            res.pos_x      <= x_reg;
            res.pos_y      <= y_val;
            res.pos_z      <= z_reg;
            res.corner_a   <= '0;
            res.corner_b   <= '0;
            res.corner_c   <= '0;
            res.final_item <= 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/uv_sphere_mesh_generator_tb.sv
// Testbench for the UV sphere mesh generator: directed table, then random mesh runs.
// Depends on uvs_pkg, the channel interfaces and the uv_sphere_mesh_generator top level.
`timescale 1ns / 100ps

module uv_sphere_mesh_generator_tb;
    import uvs_pkg::*;

    localparam int MAX_DIVS  = 64;
    localparam int FRAC_BITS = 15;
    localparam int WATCHDOG_LIMIT = 4000;
    // A request that yields nothing may still be in flight; this covers a ring vertex.
    localparam int QUIET_CYCLES = 120;
    localparam int RANDOM_ITEMS = 1650;
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI    = 1'b1;
    localparam logic [15:0] POLE_POS = 16'sd16384;
    localparam logic [15:0] POLE_NEG = -16'sd16384;

    typedef struct packed {
        logic        kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [11:0] a;
        logic [11:0] b;
        logic [11:0] c;
        logic        fin;
    } mesh_item_t;

    // One row of the directed table. When known is set the expected item (or the
    // absence of one, when none is set) is typed in; otherwise the predictor decides.
    typedef struct {
        logic       restart;
        logic       known;
        logic       none;
        mesh_item_t item;
    } table_row_t;

    logic clk;
    logic rst_n;

    uvs_cfg_if cfg ();
    uvs_req_if req ();
    uvs_res_if res ();

    uv_sphere_mesh_generator #(
        .MAX_DIVS(MAX_DIVS),
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .req(req),
        .res(res)
    );

    // The clock runs at 100 MHz.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the block's registers and generation state.
    logic [6:0]   lat_reg;
    logic [6:0]   lng_reg;
    gen_phase_t   phase;
    int unsigned  ring;
    int unsigned  band;
    logic         upper_done;
    int unsigned  bands;
    int unsigned  segments;

    mesh_item_t   pending_items[$];
    int           fail_count;
    int           quiet_count;
    int           items_sent;
    logic         gaps_on;

    // The driver publishes what the directed table says about the request it is
    // presenting; the monitor picks this up at the transfer.
    logic         row_known;
    logic         row_none;
    mesh_item_t   row_item;

    // Sine of a quarter wave, r in 0..16384, returned in unsigned Q30.
    function automatic logic [63:0] quarter_wave(logic [31:0] r);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] p;
        t = 64'(r) << 16;
        u = (t * t) >> 30;
        p = 64'(K9);
        p = 64'(K7) - ((p * u) >> 30);
        p = 64'(K5) - ((p * u) >> 30);
        p = 64'(K3) - ((p * u) >> 30);
        p = 64'(K1) - ((p * u) >> 30);
        p = (p * t) >> 30;
        return (p > 64'(ONE_Q30)) ? 64'(ONE_Q30) : p;
    endfunction

    // Sine of a 16-bit turn phase: magnitude and sign kept apart.
    function automatic logic [63:0] turn_sine(logic [15:0] ph, output logic neg);
        logic [1:0]  q;
        logic [31:0] r;
        q = ph[15:14];
        r = {18'd0, ph[13:0]};
        neg = q[1];
        return quarter_wave(q[0] ? 32'd16384 - r : r);
    endfunction

    function automatic logic [15:0] apply_sign(logic [63:0] mag, logic neg);
        return neg ? 16'(64'd0 - mag) : 16'(mag);
    endfunction

    function automatic int unsigned clamp_divs(logic [6:0] v, int unsigned lo);
        if (v < lo)
            return lo;
        if (v > MAX_DIVS)
            return MAX_DIVS;
        return v;
    endfunction

    function automatic mesh_item_t make_vertex(logic [15:0] x, logic [15:0] y,
                                               logic [15:0] z);
        mesh_item_t m;
        m = '0;
        m.kind = KIND_VERTEX;
        m.x = x;
        m.y = y;
        m.z = z;
        return m;
    endfunction

    function automatic mesh_item_t make_triangle(int unsigned a, int unsigned b,
                                                 int unsigned c, logic fin);
        mesh_item_t m;
        m = '0;
        m.kind = KIND_TRI;
        m.a = 12'(a);
        m.b = 12'(b);
        m.c = 12'(c);
        m.fin = fin;
        return m;
    endfunction

    // Advances the shadow state by one request; returns 1 when a mesh item results.
    function automatic logic next_mesh_item(logic restart, output mesh_item_t m);
        logic [15:0] lng_ph;
        logic [15:0] lat_ph;
        logic [63:0] sl, cl, sa, ca;
        logic        sl_n, cl_n, sa_n, ca_n;
        int unsigned rows;
        int unsigned left;
        int unsigned right;
        logic        fin;
        logic        advance;
        m = '0;
        if (restart)
        begin
            bands = clamp_divs(lat_reg, 2);
            segments = clamp_divs(lng_reg, 3);
            ring = 0;
            band = 0;
            upper_done = 1'b0;
            phase = PH_BOTTOM;
            m = make_vertex(16'd0, POLE_POS, 16'd0);
            return 1'b1;
        end
        case (phase)
            PH_BOTTOM:
            begin
                phase = PH_RING;
                m = make_vertex(16'd0, POLE_NEG, 16'd0);
                return 1'b1;
            end
            PH_RING:
            begin
                lng_ph = 16'(((64'(ring) << 16) + segments / 2) / segments);
                lat_ph = 16'(((64'(band + 1) << 15) + bands / 2) / bands);
                sl = turn_sine(lng_ph, sl_n);
                cl = turn_sine(lng_ph + QUARTER_TURN, cl_n);
                sa = turn_sine(lat_ph, sa_n);
                ca = turn_sine(lat_ph + QUARTER_TURN, ca_n);
                // Products carry 0.5 in the shift and round half up before the sign.
                m = make_vertex(
                    apply_sign((sl * sa + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS),
                               sl_n != sa_n),
                    apply_sign((ca + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS), ca_n),
                    apply_sign((cl * sa + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS),
                               cl_n != sa_n));
                band++;
                if (band >= bands - 1)
                begin
                    band = 0;
                    ring++;
                    if (ring >= segments)
                    begin
                        ring = 0;
                        phase = PH_TRI;
                    end
                end
                return 1'b1;
            end
            PH_TRI:
            begin
                rows = bands - 1;
                left = ring * rows;
                right = ((ring + 1 >= segments) ? 0 : ring + 1) * rows;
                fin = 1'b0;
                advance = 1'b1;
                if (band == 0)
                    m = make_triangle(0, 2 + left, 2 + right, 1'b0);
                else if (band == bands - 1)
                begin
                    // Fan to the bottom pole; the last ring closes the mesh.
                    fin = (ring == segments - 1);
                    m = make_triangle(1, 2 + right + band - 1, 2 + left + band - 1, fin);
                end
                else if (!upper_done)
                begin
                    m = make_triangle(2 + right + band - 1, 2 + left + band - 1,
                                      2 + left + band, 1'b0);
                    upper_done = 1'b1;
                    advance = 1'b0;
                end
                else
                begin
                    m = make_triangle(2 + left + band, 2 + right + band,
                                      2 + right + band - 1, 1'b0);
                    upper_done = 1'b0;
                end
                if (advance)
                begin
                    band++;
                    if (band >= bands)
                    begin
                        band = 0;
                        ring++;
                    end
                    if (fin)
                    begin
                        phase = PH_IDLE;
                        ring = 0;
                        band = 0;
                    end
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: every transfer is seen here, with values from before the edge.
    always @(posedge clk)
    begin : monitor
        mesh_item_t predicted;
        mesh_item_t want;
        logic       produced;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_LAT_DIVS)
                    lat_reg <= cfg.data;
                else if (cfg.index == CFG_LNG_DIVS)
                    lng_reg <= cfg.data;
            end
            if (req.valid && req.ready)
            begin
                produced = next_mesh_item(req.restart, predicted);
                if (row_known && (row_none == produced))
                begin
                    $display("%0t: result presence mismatch, expected %0d actual %0d",
                             $time, !row_none, produced);
                    fail_count++;
                end
                if (produced)
                    pending_items.push_back(row_known ? row_item : predicted);
            end
            if (res.valid && res.ready)
            begin
                if (pending_items.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, {res.item_kind, res.pos_x, res.pos_y, res.pos_z,
                                     res.corner_a, res.corner_b, res.corner_c,
                                     res.final_item});
                    fail_count++;
                end
                else
                begin
                    want = pending_items.pop_front();
                    check_field("item_kind", 16'(want.kind), 16'(res.item_kind));
                    check_field("pos_x", want.x, res.pos_x);
                    check_field("pos_y", want.y, res.pos_y);
                    check_field("pos_z", want.z, res.pos_z);
                    check_field("corner_a", 16'(want.a), 16'(res.corner_a));
                    check_field("corner_b", 16'(want.b), 16'(res.corner_b));
                    check_field("corner_c", 16'(want.c), 16'(res.corner_c));
                    check_field("final_item", 16'(want.fin), 16'(res.final_item));
                end
            end
            if ((cfg.valid && cfg.ready) || (req.valid && req.ready)
                || (res.valid && res.ready))
                quiet_count <= 0;
            else
                quiet_count <= quiet_count + 1;
        end
    end

    // The result side stalls in random bursts while gaps are enabled.
    always @(negedge clk)
    begin : result_stall
        int stall_left;
        if (!rst_n)
        begin
            stall_left = 0;
            res.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                res.ready <= 1'b1;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 7);
            res.ready <= 1'b0;
        end
        else
            res.ready <= 1'b1;
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (quiet_count >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Presents one request, possibly after an idle burst, and holds it until transfer.
    task automatic send_request(logic restart, logic known, logic none, mesh_item_t item);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.restart <= restart;
        row_known <= known;
        row_none <= none;
        row_item <= item;
        forever
        begin
            @(posedge clk);
            if (req.ready)
                break;
        end
        items_sent++;
    endtask

    task automatic send_predicted(logic restart);
        send_request(restart, 1'b0, 1'b0, '0);
    endtask

    // Lowers valid, waits for all outstanding results, then lets any silent request settle.
    task automatic drain;
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending_items.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [6:0] data);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data <= data;
        forever
        begin
            @(posedge clk);
            if (cfg.ready)
                break;
        end
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Writes both divisors in random order; sometimes an unused index too.
    task automatic set_divisors(logic [6:0] lat, logic [6:0] lng);
        if ($urandom_range(0, 3) == 0)
            write_register(2'($urandom_range(2, 3)), 7'($urandom));
        if ($urandom_range(0, 1))
        begin
            write_register(CFG_LAT_DIVS, lat);
            write_register(CFG_LNG_DIVS, lng);
        end
        else
        begin
            write_register(CFG_LNG_DIVS, lng);
            write_register(CFG_LAT_DIVS, lat);
        end
    endtask

    // One random mesh run: a restart, then follow-up requests that usually walk the
    // whole mesh, sometimes stop early, and sometimes run past the final triangle.
    task automatic mesh_run(int unsigned cap);
        int unsigned run_bands;
        int unsigned run_segments;
        int unsigned total;
        int unsigned count;
        run_bands = clamp_divs(lat_reg, 2);
        run_segments = clamp_divs(lng_reg, 3);
        total = 2 + run_segments * (run_bands - 1) + run_segments * (2 * run_bands - 2);
        case ($urandom_range(0, 5))
            0: count = $urandom_range(0, total);
            1: count = total + $urandom_range(1, 4);
            default: count = total - 1;
        endcase
        if (count > cap)
            count = cap;
        send_predicted(1'b1);
        repeat (count)
            send_predicted($urandom_range(0, 19) == 0);
    endtask

    table_row_t directed_rows[$];
    logic [6:0] lat_pick;
    logic [6:0] lng_pick;
    int         phase_no;

    initial
    begin
        // Every input is known from time zero, before reset is released.
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.restart = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_LAT_DIVS;
        cfg.data = DIVS_RESET;
        row_known = 1'b0;
        row_none = 1'b0;
        row_item = '0;
        gaps_on = 1'b1;
        fail_count = 0;
        quiet_count = 0;
        items_sent = 0;
        lat_reg = DIVS_RESET;
        lng_reg = DIVS_RESET;
        phase = PH_IDLE;
        ring = 0;
        band = 0;
        upper_done = 1'b0;
        bands = 8;
        segments = 8;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the divisors at their reset value of eight. A request while idle
        // yields nothing; each restart gives the top pole, and the next plain request the bottom.
        directed_rows.push_back('{1'b0, 1'b1, 1'b1, '0});
        directed_rows.push_back('{1'b0, 1'b1, 1'b1, '0});
        directed_rows.push_back('{1'b1, 1'b1, 1'b0, make_vertex(16'd0, POLE_POS, 16'd0)});
        directed_rows.push_back('{1'b0, 1'b1, 1'b0, make_vertex(16'd0, POLE_NEG, 16'd0)});
        repeat (9) directed_rows.push_back('{1'b0, 1'b0, 1'b0, '0});
        directed_rows.push_back('{1'b1, 1'b1, 1'b0, make_vertex(16'd0, POLE_POS, 16'd0)});
        directed_rows.push_back('{1'b1, 1'b1, 1'b0, make_vertex(16'd0, POLE_POS, 16'd0)});
        directed_rows.push_back('{1'b0, 1'b1, 1'b0, make_vertex(16'd0, POLE_NEG, 16'd0)});
        repeat (6) directed_rows.push_back('{1'b0, 1'b0, 1'b0, '0});
        foreach (directed_rows[i])
            send_request(directed_rows[i].restart, directed_rows[i].known,
                         directed_rows[i].none, directed_rows[i].item);
        // The sender holds off here until every expected result has come back.
        drain();

        // Random part. The first phases cover the smallest, largest and saturated
        // divisor settings; later ones are mostly small meshes.
        phase_no = 0;
        while (items_sent < RANDOM_ITEMS + directed_rows.size())
        begin
            case (phase_no)
                0: begin lat_pick = 7'd2;   lng_pick = 7'd3;   end
                1: begin lat_pick = 7'd0;   lng_pick = 7'd0;   end
                2: begin lat_pick = 7'd64;  lng_pick = 7'd64;  end
                3: begin lat_pick = 7'd127; lng_pick = 7'd127; end
                4: begin lat_pick = 7'd1;   lng_pick = 7'd2;   end
                default:
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        lat_pick = 7'($urandom);
                        lng_pick = 7'($urandom);
                    end
                    else
                    begin
                        lat_pick = 7'($urandom_range(2, 6));
                        lng_pick = 7'($urandom_range(3, 6));
                    end
                end
            endcase
            // Idling is switched off for the last stretch of the run.
            if (items_sent > RANDOM_ITEMS - 150)
                gaps_on = 1'b0;
            set_divisors(lat_pick, lng_pick);
            // Stray requests between runs; they yield nothing once a mesh is done.
            if ($urandom_range(0, 2) == 0)
                send_predicted(1'b0);
            repeat ($urandom_range(1, 3))
            begin
                // Large meshes are cut short to keep the run length reasonable.
                mesh_run((clamp_divs(lat_pick, 2) * clamp_divs(lng_pick, 3) > 64)
                         ? 150 : 1000);
            end
            drain();
            phase_no++;
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
